[hw/rtl/qmlp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmlp_pkg
// Shared sizes, weight-store layout, request codes and control structs of the
// Q8.8 MLP ratio inference block.
// ----------------------------------------------------------------------------
package qmlp_pkg;

  localparam int N_INPUTS   = 4;
  localparam int N_HIDDEN   = 8;
  localparam int FRAC_BITS  = 8;
  localparam int N_FEATURES = 4;

  localparam int WORD_W = 16;
  localparam int H_W    = 15;
  localparam int HIDDEN_MAX = 32767;

  // weight store layout
  localparam int W1_BASE = 0;
  localparam int B1_BASE = N_HIDDEN * N_INPUTS;
  localparam int W2_BASE = B1_BASE + N_HIDDEN;
  localparam int B2_SLOT = W2_BASE + N_HIDDEN;

  localparam int Q_ONE = 1 << FRAC_BITS;
  localparam logic [WORD_W-1:0] B1_RESET = WORD_W'(Q_ONE / 8);
  localparam logic [WORD_W-1:0] B2_RESET = WORD_W'(Q_ONE);

  localparam logic signed [WORD_W-1:0] FLOOR_RESET = 16'sd64;
  localparam logic signed [WORD_W-1:0] CEIL_RESET  = 16'sd1024;

  localparam int PROD_W = 2 * WORD_W;
  localparam int HACC_W = PROD_W + $clog2(N_INPUTS + 1) + 1;
  localparam int OACC_W = PROD_W + $clog2(N_HIDDEN + 1) + 1;

  localparam int J_W = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
  localparam int K_W = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;

  localparam logic REQ_INFER = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [0:0] CFG_FLOOR = 1'b0;
  localparam logic [0:0] CFG_CEIL  = 1'b1;

  typedef struct packed {
    logic           load;
    logic           mac;
    logic [J_W-1:0] sel;
    logic           act;
    logic           prod;
  } lane_ctrl_t;

  typedef struct packed {
    logic [N_INPUTS-1:0] w1_we;
    logic                b1_we;
    logic                w2_we;
    logic [WORD_W-1:0]   value;
  } lane_wr_t;

  typedef struct packed {
    logic              load;
    logic              add;
    logic [K_W-1:0]    sel;
    logic              b2_we;
    logic [WORD_W-1:0] value;
  } merge_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/qmlp_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmlp_lane
// One hidden unit: its first-layer weights, bias and output weight, a
// multiply-accumulate over the inputs, ReLU clamp and the output-weight product.
// ----------------------------------------------------------------------------
module qmlp_lane (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire qmlp_pkg::lane_wr_t                 wr_i,
  input  wire qmlp_pkg::lane_ctrl_t               ctrl_i,
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] feature_i,
  output logic signed [qmlp_pkg::PROD_W-1:0]      prod_o
);

  logic [qmlp_pkg::WORD_W-1:0] w1_q [qmlp_pkg::N_INPUTS];
  logic [qmlp_pkg::WORD_W-1:0] b1_q;
  logic [qmlp_pkg::WORD_W-1:0] w2_q;

  logic signed [qmlp_pkg::HACC_W-1:0] acc_q;
  logic signed [qmlp_pkg::HACC_W-1:0] bias_ext;
  logic signed [qmlp_pkg::HACC_W-1:0] shifted;
  logic signed [qmlp_pkg::PROD_W-1:0] mul;
  logic        [qmlp_pkg::H_W-1:0]    h_d;
  logic        [qmlp_pkg::H_W-1:0]    h_q;
  logic signed [qmlp_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < qmlp_pkg::N_INPUTS; j++) begin
        w1_q[j] <= '0;
      end
      b1_q <= qmlp_pkg::B1_RESET;
      w2_q <= '0;
    end else begin
      for (int j = 0; j < qmlp_pkg::N_INPUTS; j++) begin
        if (wr_i.w1_we[j]) begin
          w1_q[j] <= wr_i.value;
        end
      end
      if (wr_i.b1_we) begin
        b1_q <= wr_i.value;
      end
      if (wr_i.w2_we) begin
        w2_q <= wr_i.value;
      end
    end
  end

  assign mul      = $signed(w1_q[ctrl_i.sel]) * feature_i;
  assign bias_ext = $signed(qmlp_pkg::HACC_W'($signed(b1_q))) <<< qmlp_pkg::FRAC_BITS;
  assign shifted  = acc_q >>> qmlp_pkg::FRAC_BITS;

  // ReLU, then saturate to the positive Q8.8 range
  always_comb begin
    if (shifted[qmlp_pkg::HACC_W-1]) begin
      h_d = '0;
    end else if (shifted > $signed(qmlp_pkg::HACC_W'(qmlp_pkg::HIDDEN_MAX))) begin
      h_d = qmlp_pkg::H_W'(qmlp_pkg::HIDDEN_MAX);
    end else begin
      h_d = shifted[qmlp_pkg::H_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= bias_ext;
    end else if (ctrl_i.mac) begin
      acc_q <= acc_q + qmlp_pkg::HACC_W'(mul);
    end
    if (ctrl_i.act) begin
      h_q <= h_d;
    end
    if (ctrl_i.prod) begin
      prod_q <= $signed({1'b0, h_q}) * $signed(w2_q);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

[hw/rtl/qmlp_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmlp_merge
// Output neuron: walks the lane products into one accumulator on top of the
// output bias, then scales and clamps to the configured ratio range.
// ----------------------------------------------------------------------------
module qmlp_merge (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire qmlp_pkg::merge_ctrl_t              ctrl_i,
  input  wire logic signed [qmlp_pkg::PROD_W-1:0] prod_i [qmlp_pkg::N_HIDDEN],
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] floor_i,
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] ceil_i,
  output logic signed [qmlp_pkg::WORD_W-1:0]      ratio_o
);

  logic        [qmlp_pkg::WORD_W-1:0] b2_q;
  logic signed [qmlp_pkg::OACC_W-1:0] acc_q;
  logic signed [qmlp_pkg::OACC_W-1:0] bias_ext;
  logic signed [qmlp_pkg::OACC_W-1:0] shifted;
  logic signed [qmlp_pkg::OACC_W-1:0] floor_ext;
  logic signed [qmlp_pkg::OACC_W-1:0] ceil_ext;
  logic signed [qmlp_pkg::OACC_W-1:0] lo_clamped;
  logic signed [qmlp_pkg::OACC_W-1:0] clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_q <= qmlp_pkg::B2_RESET;
    end else if (ctrl_i.b2_we) begin
      b2_q <= ctrl_i.value;
    end
  end

  assign bias_ext = $signed(qmlp_pkg::OACC_W'($signed(b2_q))) <<< qmlp_pkg::FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= bias_ext;
    end else if (ctrl_i.add) begin
      acc_q <= acc_q + qmlp_pkg::OACC_W'(prod_i[ctrl_i.sel]);
    end
  end

  // floor first, then ceiling: the ceiling wins when they cross
  assign shifted    = acc_q >>> qmlp_pkg::FRAC_BITS;
  assign floor_ext  = qmlp_pkg::OACC_W'(floor_i);
  assign ceil_ext   = qmlp_pkg::OACC_W'(ceil_i);
  assign lo_clamped = (shifted < floor_ext) ? floor_ext : shifted;
  assign clamped    = (lo_clamped > ceil_ext) ? ceil_ext : lo_clamped;
  assign ratio_o    = clamped[qmlp_pkg::WORD_W-1:0];

endmodule
`default_nettype wire

[hw/rtl/quantized_mlp_ratio_infer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quantized_mlp_ratio_infer
// Q8.8 MLP (4 inputs, 8 ReLU hidden units, 1 clamped output) with a
// writable weight store and ratio clamp registers.
// ----------------------------------------------------------------------------
// A weight-write word is taken while idle and returns nothing. An inference
// word steps from acceptance to the result register through the MAC, ACT,
// PROD, SUM and FIN states: every hidden unit has its own lane with one
// multiplier stepping through the inputs, then a single output accumulator
// walks the eight lane products one per cycle. The next word can be taken
// once the sequencer is back in idle, which it enters as the result is
// loaded. One word is in flight at a time; the next word is taken
// while a finished ratio still waits in the output register, and a ratio that
// finishes while the output register is still held stalls the input until it
// moves. Weights sit in flip-flops and hold their neutral defaults from reset,
// so there is no start-up clear.
// ----------------------------------------------------------------------------
module quantized_mlp_ratio_infer (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire                                     req_type_i,
  input  wire  [5:0]                              weight_index_i,
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] weight_value_i,
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] feature_0_i,
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] feature_1_i,
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] feature_2_i,
  input  wire logic signed [qmlp_pkg::WORD_W-1:0] feature_3_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic signed [qmlp_pkg::WORD_W-1:0]      ratio_o,
  input  wire                                     cfg_we_i,
  input  wire  [0:0]                              cfg_idx_i,
  input  wire  [qmlp_pkg::WORD_W-1:0]             cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_ACT  = 3'd2;
  localparam logic [2:0] ST_PROD = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [qmlp_pkg::J_W-1:0] j_q, j_d;
  logic [qmlp_pkg::K_W-1:0] k_q, k_d;

  logic in_acc, infer_acc, write_acc, out_free, fin_load;

  logic signed [qmlp_pkg::WORD_W-1:0] feat     [qmlp_pkg::N_FEATURES];
  logic signed [qmlp_pkg::WORD_W-1:0] feat_all [qmlp_pkg::N_INPUTS];
  logic signed [qmlp_pkg::WORD_W-1:0] x_q      [qmlp_pkg::N_INPUTS];

  logic signed [qmlp_pkg::WORD_W-1:0] floor_q, ceil_q;
  logic signed [qmlp_pkg::WORD_W-1:0] ratio_d;
  logic signed [qmlp_pkg::WORD_W-1:0] ratio_q;
  logic out_valid_q, out_valid_d;

  qmlp_pkg::lane_ctrl_t  lane_ctrl;
  qmlp_pkg::lane_wr_t    lane_wr [qmlp_pkg::N_HIDDEN];
  qmlp_pkg::merge_ctrl_t merge_ctrl;
  logic signed [qmlp_pkg::PROD_W-1:0] lane_prod [qmlp_pkg::N_HIDDEN];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign infer_acc  = in_acc && (req_type_i == qmlp_pkg::REQ_INFER);
  assign write_acc  = in_acc && (req_type_i == qmlp_pkg::REQ_WRITE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_load   = (state_q == ST_FIN) && out_free;

  // inputs past the feature fields read as zero
  assign feat[0] = feature_0_i;
  assign feat[1] = feature_1_i;
  assign feat[2] = feature_2_i;
  assign feat[3] = feature_3_i;

  for (genvar j = 0; j < qmlp_pkg::N_INPUTS; j++) begin : g_feat
    if (j < qmlp_pkg::N_FEATURES) begin : g_used
      assign feat_all[j] = feat[j];
    end else begin : g_zero
      assign feat_all[j] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (infer_acc) begin
      for (int j = 0; j < qmlp_pkg::N_INPUTS; j++) begin
        x_q[j] <= feat_all[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= qmlp_pkg::FLOOR_RESET;
      ceil_q  <= qmlp_pkg::CEIL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qmlp_pkg::CFG_FLOOR: floor_q <= cfg_data_i;
        qmlp_pkg::CFG_CEIL:  ceil_q  <= cfg_data_i;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        j_d = '0;
        if (infer_acc) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (j_q == qmlp_pkg::J_W'(qmlp_pkg::N_INPUTS - 1)) begin
          state_d = ST_ACT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_ACT: begin
        state_d = ST_PROD;
      end
      ST_PROD: begin
        k_d     = '0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (k_q == qmlp_pkg::K_W'(qmlp_pkg::N_HIDDEN - 1)) begin
          state_d = ST_FIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign lane_ctrl.load = infer_acc;
  assign lane_ctrl.mac  = (state_q == ST_MAC);
  assign lane_ctrl.sel  = j_q;
  assign lane_ctrl.act  = (state_q == ST_ACT);
  assign lane_ctrl.prod = (state_q == ST_PROD);

  for (genvar i = 0; i < qmlp_pkg::N_HIDDEN; i++) begin : g_lane
    for (genvar j = 0; j < qmlp_pkg::N_INPUTS; j++) begin : g_w1
      assign lane_wr[i].w1_we[j] = write_acc &&
        (32'(weight_index_i) == 32'(qmlp_pkg::W1_BASE + i * qmlp_pkg::N_INPUTS + j));
    end
    assign lane_wr[i].b1_we = write_acc &&
      (32'(weight_index_i) == 32'(qmlp_pkg::B1_BASE + i));
    assign lane_wr[i].w2_we = write_acc &&
      (32'(weight_index_i) == 32'(qmlp_pkg::W2_BASE + i));
    assign lane_wr[i].value = weight_value_i;

    qmlp_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (lane_wr[i]),
      .ctrl_i    (lane_ctrl),
      .feature_i (x_q[j_q]),
      .prod_o    (lane_prod[i])
    );
  end

  assign merge_ctrl.load  = (state_q == ST_PROD);
  assign merge_ctrl.add   = (state_q == ST_SUM);
  assign merge_ctrl.sel   = k_q;
  assign merge_ctrl.b2_we = write_acc &&
    (32'(weight_index_i) == 32'(qmlp_pkg::B2_SLOT));
  assign merge_ctrl.value = weight_value_i;

  qmlp_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (merge_ctrl),
    .prod_i  (lane_prod),
    .floor_i (floor_q),
    .ceil_i  (ceil_q),
    .ratio_o (ratio_d)
  );

  // output register: load a finished ratio, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      ratio_q <= ratio_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ratio_o     = ratio_q;

  a_infer_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infer_acc |=> state_q == ST_MAC)
    else $error("accepted inference word did not start the lanes");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_acc |=> state_q == ST_IDLE)
    else $error("weight write left the idle state");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result appeared without a finished inference");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && !out_valid_o |=> out_valid_o && (state_q == ST_IDLE))
    else $error("finished inference not moved to the output register");

endmodule
`default_nettype wire
